// ===== hw/rtl/sqch_pkg.sv =====
// Types and codes shared by the square channel with sweep.
package sqch_pkg;

   // Item actions
   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_STEP  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_SWEEP    = 3'd0;
   localparam logic [2:0] REG_DUTY_LEN = 3'd1;
   localparam logic [2:0] REG_ENVELOPE = 3'd2;
   localparam logic [2:0] REG_FREQ_LO  = 3'd3;
   localparam logic [2:0] REG_FREQ_HI  = 3'd4;
   localparam logic [2:0] REG_POWER    = 3'd5;

   // Fixed values of the channel
   localparam logic [6:0]  LEN_FULL      = 7'd64;
   localparam logic [6:0]  LEN_FULL_LESS = 7'd63;
   localparam logic [11:0] FREQ_SPAN     = 12'd2048;
   localparam logic [3:0]  SWEEP_DEF_CNT = 4'd8;
   localparam logic [4:0]  VOL_WRAP      = 5'd16;
   localparam logic [3:0]  VOL_MAX       = 4'd15;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] reg_index;
      logic [7:0] write_data;
   } sqch_req_type;

   typedef struct packed {
      logic        apu_on;
      logic        channel_on;
      logic        dac_on;
      logic [3:0]  volume_level;
      logic [1:0]  duty_select;
      logic [2:0]  duty_position;
      logic [10:0] frequency;
   } sqch_rsp_type;

endpackage

// ===== hw/rtl/sqch_in_reg.sv =====
// Input register: holds one accepted item until the core can take it.
module sqch_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sqch_pkg::sqch_req_type req_data,
   input  logic                  out_free,
   output logic                  item_valid,
   output logic                  advance,
   output sqch_pkg::sqch_req_type item
);
   import sqch_pkg::*;

   logic          valid_ff, valid_in;
   sqch_req_type  item_ff;
   logic          take;

   // Move the held item on when the result register has room
   assign advance   = valid_ff & out_free;
   assign req_stall = valid_ff & ~out_free;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new item
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ===== hw/rtl/sqch_core.sv =====
// Channel state and the next-state logic for one item.
module sqch_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   color_mode,
   input  logic                   advance,
   input  sqch_pkg::sqch_req_type item,
   output sqch_pkg::sqch_rsp_type rsp_next
);
   import sqch_pkg::*;

   typedef struct packed {
      logic        power_on;
      logic [7:0]  sweep_reg;
      logic [7:0]  envelope_reg;
      logic [1:0]  duty_sel;
      logic [6:0]  length_left;
      logic        length_on;
      logic [10:0] freq_value;
      logic [13:0] freq_countdown;
      logic [2:0]  duty_pos;
      logic        chan_enabled;
      logic        dac_enabled;
      logic [3:0]  vol;
      logic [7:0]  env_params;
      logic [2:0]  env_countdown;
      logic        env_running;
      logic [6:0]  sweep_params;
      logic [3:0]  sweep_countdown;
      logic        sweep_active;
      logic        negate_used;
      logic [10:0] sweep_shadow;
      logic [2:0]  seq_step;
      logic        first_half;
   } sqch_state_type;

   sqch_state_type st_ff, st_in;

   // New shadow frequency for one sweep update
   function automatic logic [11:0] sweep_calc(input logic [10:0] shadow,
                                             input logic [6:0] prm);
      logic [10:0] delta;
      delta = shadow >> prm[2:0];
      if (prm[3]) begin
         return {1'b0, shadow} - {1'b0, delta};
      end else begin
         return {1'b0, shadow} + {1'b0, delta};
      end
   endfunction

   // Timer reload for a frequency
   function automatic logic [13:0] timer_period(input logic [10:0] freq);
      logic [11:0] diff;
      diff = FREQ_SPAN - {1'b0, freq};
      return {diff, 2'b00};
   endfunction

   // State after reset: powered, full length, all else clear
   function automatic sqch_state_type reset_value();
      sqch_state_type r;
      r             = '0;
      r.power_on    = 1'b1;
      r.length_left = LEN_FULL;
      return r;
   endfunction

   always_comb begin
      sqch_state_type s;
      logic [4:0]  v;
      logic [11:0] nf;
      logic [11:0] nf2;
      logic [13:0] period;
      logic        old_up;
      logic        new_up;
      logic [7:0]  d;
      s      = st_ff;
      d      = item.write_data;
      v      = 5'd0;
      nf     = 12'd0;
      nf2    = 12'd0;
      period = 14'd0;
      old_up = 1'b0;
      new_up = 1'b0;

      unique case (item.action)
         ACT_WRITE: begin
            if (item.reg_index == REG_POWER) begin
               if (d[7]) begin
                  // Power up only from off
                  if (!s.power_on) begin
                     if (color_mode) begin
                        s.length_left = 7'd0;
                     end
                     s.seq_step = 3'd0;
                     s.power_on = 1'b1;
                  end
               end else begin
                  // Power down: clear registers and channel outputs
                  s.sweep_reg      = 8'd0;
                  s.sweep_params   = 7'd0;
                  s.duty_sel       = 2'd0;
                  if (color_mode) begin
                     s.length_left = LEN_FULL;
                  end
                  s.envelope_reg   = 8'd0;
                  s.env_params     = 8'd0;
                  s.freq_value     = 11'd0;
                  s.length_on      = 1'b0;
                  s.chan_enabled   = 1'b0;
                  s.dac_enabled    = 1'b0;
                  s.vol            = 4'd0;
                  s.freq_countdown = 14'd0;
                  s.duty_pos       = 3'd0;
                  s.first_half     = 1'b0;
                  s.power_on       = 1'b0;
               end
            end else if (s.power_on) begin
               unique case (item.reg_index)
                  REG_SWEEP: begin
                     s.sweep_reg    = d;
                     s.sweep_params = d[6:0];
                     if (!d[3] && s.negate_used) begin
                        s.chan_enabled = 1'b0;
                     end
                  end
                  REG_DUTY_LEN: begin
                     s.duty_sel    = d[7:6];
                     s.length_left = LEN_FULL - {1'b0, d[5:0]};
                  end
                  REG_ENVELOPE: begin
                     // Volume changes while running
                     new_up = d[3];
                     old_up = s.env_params[3];
                     v      = {1'b0, s.vol};
                     s.envelope_reg = d;
                     if (s.chan_enabled) begin
                        if (((s.env_params[2:0] == 3'd0) && s.env_running) || !old_up) begin
                           v = v + 5'd1;
                        end
                        if (new_up != old_up) begin
                           v = VOL_WRAP - v;
                        end
                        s.vol = v[3:0];
                     end
                     s.env_params  = d;
                     s.dac_enabled = (d[7:3] != 5'd0);
                     if (!s.dac_enabled) begin
                        s.chan_enabled = 1'b0;
                     end
                  end
                  REG_FREQ_LO: begin
                     s.freq_value = {s.freq_value[10:8], d};
                  end
                  REG_FREQ_HI: begin
                     s.freq_value = {d[2:0], s.freq_value[7:0]};
                     // Extra length clock when enabling in the first half
                     if (s.first_half && d[6] && !s.length_on &&
                         (s.length_left != 7'd0)) begin
                        s.length_left = s.length_left - 7'd1;
                        if (s.length_left == 7'd0) begin
                           s.chan_enabled = 1'b0;
                        end
                     end
                     s.length_on = d[6];
                     if (d[7]) begin
                        // Trigger
                        period          = timer_period(s.freq_value);
                        s.chan_enabled  = s.dac_enabled;
                        s.sweep_params  = s.sweep_reg[6:0];
                        s.sweep_shadow  = s.freq_value;
                        s.sweep_countdown = (s.sweep_params[6:4] != 3'd0) ?
                                            {1'b0, s.sweep_params[6:4]} : SWEEP_DEF_CNT;
                        s.sweep_active  = (s.sweep_params[6:4] != 3'd0) ||
                                          (s.sweep_params[2:0] != 3'd0);
                        s.negate_used   = 1'b0;
                        if (s.sweep_params[2:0] != 3'd0) begin
                           nf = sweep_calc(s.sweep_shadow, s.sweep_params);
                           if (nf[11]) begin
                              s.chan_enabled = 1'b0;
                           end
                           if (s.sweep_params[3]) begin
                              s.negate_used = 1'b1;
                           end
                        end
                        s.env_params    = s.envelope_reg;
                        s.env_countdown = s.env_params[2:0];
                        s.vol           = s.env_params[7:4];
                        s.env_running   = 1'b1;
                        if (s.length_left == 7'd0) begin
                           s.length_left = (s.length_on && s.first_half) ?
                                           LEN_FULL_LESS : LEN_FULL;
                        end
                        s.freq_countdown = {period[13:2], s.freq_countdown[1:0]};
                        s.duty_pos       = 3'd0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ACT_STEP: begin
            if (s.power_on) begin
               // Length clock on even steps
               if (!s.seq_step[0]) begin
                  if (s.length_on && (s.length_left != 7'd0)) begin
                     s.length_left = s.length_left - 7'd1;
                     if (s.length_left == 7'd0) begin
                        s.chan_enabled = 1'b0;
                     end
                  end
               end
               // Sweep clock on steps 2 and 6
               if (s.seq_step[1:0] == 2'd2) begin
                  if (s.sweep_countdown != 4'd0) begin
                     s.sweep_countdown = s.sweep_countdown - 4'd1;
                  end
                  if (s.sweep_countdown == 4'd0) begin
                     s.sweep_countdown = (s.sweep_params[6:4] != 3'd0) ?
                                         {1'b0, s.sweep_params[6:4]} : SWEEP_DEF_CNT;
                     if (s.sweep_active && (s.sweep_params[6:4] != 3'd0)) begin
                        nf = sweep_calc(s.sweep_shadow, s.sweep_params);
                        if (nf[11]) begin
                           s.chan_enabled = 1'b0;
                        end
                        if (s.sweep_params[3]) begin
                           s.negate_used = 1'b1;
                        end
                        if (!nf[11] && (s.sweep_params[2:0] != 3'd0)) begin
                           s.sweep_shadow = nf[10:0];
                           s.freq_value   = nf[10:0];
                           // Overflow check on the following value
                           nf2 = sweep_calc(s.sweep_shadow, s.sweep_params);
                           if (nf2[11]) begin
                              s.chan_enabled = 1'b0;
                           end
                           if (s.sweep_params[3]) begin
                              s.negate_used = 1'b1;
                           end
                        end
                     end
                  end
               end
               // Envelope clock on step 7
               if ((s.seq_step == 3'd7) && (s.env_params[2:0] != 3'd0) && s.env_running) begin
                  if (s.env_countdown != 3'd0) begin
                     s.env_countdown = s.env_countdown - 3'd1;
                  end
                  if (s.env_countdown == 3'd0) begin
                     s.env_countdown = s.env_params[2:0];
                     if ((s.vol < VOL_MAX) && s.env_params[3]) begin
                        s.vol = s.vol + 4'd1;
                     end else if ((s.vol != 4'd0) && !s.env_params[3]) begin
                        s.vol = s.vol - 4'd1;
                     end else begin
                        s.env_running = 1'b0;
                     end
                  end
               end
               s.first_half = ~s.seq_step[0];
               s.seq_step   = s.seq_step + 3'd1;
            end
         end
         ACT_TICK: begin
            if (s.power_on) begin
               // Frequency timer and duty position
               if (s.freq_countdown != 14'd0) begin
                  s.freq_countdown = s.freq_countdown - 14'd1;
               end
               if (s.freq_countdown == 14'd0) begin
                  s.freq_countdown = timer_period(s.freq_value);
                  s.duty_pos       = s.duty_pos + 3'd1;
               end
            end
         end
         default: begin
         end
      endcase

      st_in = s;
   end

   // Commit the state of each item that advances
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= reset_value();
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   // Result as seen after the item
   always_comb begin
      rsp_next.apu_on        = st_in.power_on;
      rsp_next.channel_on    = st_in.chan_enabled;
      rsp_next.dac_on        = st_in.dac_enabled;
      rsp_next.volume_level  = st_in.vol;
      rsp_next.duty_select   = st_in.duty_sel;
      rsp_next.duty_position = st_in.duty_pos;
      rsp_next.frequency     = st_in.freq_value;
   end
endmodule

// ===== hw/rtl/sqch_out_reg.sv =====
// Result register: holds one result item until the receiver takes it.
module sqch_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  sqch_pkg::sqch_rsp_type rsp_next,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sqch_pkg::sqch_rsp_type rsp_data
);
   import sqch_pkg::*;

   logic         valid_ff, valid_in;
   sqch_rsp_type data_ff;

   // Room when empty or when the held item leaves now
   assign out_free = ~valid_ff | ~rsp_stall;
   assign valid_in = advance | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= rsp_next;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

// ===== hw/rtl/square_channel_with_sweep.sv =====
// Square sound channel with frequency sweep: top level.
//
// Items arrive on req_*: a register write, a frame-sequencer step or one clock
// tick. Each item yields exactly one result item on rsp_* with the power flag,
// channel and converter enables, envelope volume, duty select, duty position
// and channel frequency as they stand after the item.
// An item is taken when valid is high and stall is low on its channel.
// rsp_valid rises after the accepting edge: the input register takes the item,
// then the next-state logic loads the result register once it has room.
// One item per cycle is sustained while rsp_stall stays low.
// When rsp_stall is high the result holds; one more item waits in the input
// register, and req_stall then rises until the result is taken.
// csr_* writes the color-mode bit (csr_ready is always high); write it only
// while no item is in flight.
// Synchronous reset empties both registers, powers the unit on, sets the length
// counter to 64 and clears all other state and the color-mode bit.
module square_channel_with_sweep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sqch_pkg::sqch_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sqch_pkg::sqch_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);
   import sqch_pkg::*;

   logic         color_mode_ff;
   logic         out_free;
   logic         advance;
   logic         item_valid;
   sqch_req_type item;
   sqch_rsp_type rsp_next;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         color_mode_ff <= csr_data;
      end
   end

   sqch_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_free   (out_free),
      .item_valid (item_valid),
      .advance    (advance),
      .item       (item)
   );

   sqch_core u_core (
      .clock      (clock),
      .reset      (reset),
      .color_mode (color_mode_ff),
      .advance    (advance & item_valid),
      .item       (item),
      .rsp_next   (rsp_next)
   );

   sqch_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rsp_next  (rsp_next),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// ===== hw/rtl/sqch_checker.sv =====
// Port checks for the square channel, bound to the top level.
module sqch_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sqch_pkg::sqch_rsp_type rsp_data
);
   import sqch_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input only backs up behind a stalled result
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled with free output");

   // Powered down means a silent channel
   a_power_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.apu_on |->
         !rsp_data.channel_on && !rsp_data.dac_on &&
         (rsp_data.volume_level == 4'd0) && (rsp_data.frequency == 11'd0))
      else $error("channel active while powered down");

   // An enabled channel has its converter on
   a_chan_dac: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.channel_on |-> rsp_data.dac_on)
      else $error("channel on with converter off");
endmodule

bind square_channel_with_sweep sqch_checker u_sqch_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/tb.sv =====
// Testbench for the square channel with sweep: random item streams checked against a predictor.
`timescale 1ns / 1ps

module tb;
   import sqch_pkg::*;

   // Codes the package leaves unnamed: the unused action and the two unused registers
   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam logic [2:0] REG_UNUSED_6 = 3'd6;
   localparam logic [2:0] REG_UNUSED_7 = 3'd7;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int PHASE_ITEMS      = 640;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int LONG_HOLD_AFTER  = 900;
   localparam int DRAIN_CYCLES     = 8;

   // Predicts the channel status after each item and checks the block's results
   class square_tracker;
      bit         color_mode;
      bit         power_on;
      bit  [7:0]  sweep_reg;
      bit  [7:0]  envelope_reg;
      bit  [1:0]  duty_sel;
      bit  [6:0]  length_left;
      bit         length_on;
      bit  [10:0] freq_value;
      bit  [13:0] freq_countdown;
      bit  [2:0]  duty_pos;
      bit         chan_en;
      bit         dac_en;
      bit  [3:0]  vol;
      bit  [7:0]  env_params;
      bit  [2:0]  env_countdown;
      bit         env_running;
      bit  [6:0]  sweep_params;
      bit  [3:0]  sweep_countdown;
      bit         sweep_active;
      bit         negate_used;
      bit  [10:0] sweep_shadow;
      bit  [2:0]  seq_step;
      bit         first_half;

      sqch_rsp_type status_q[$];
      int errors;
      int items;
      int checked;
      int triggers;
      int power_downs;

      function new();
         reset_state();
         errors      = 0;
         items       = 0;
         checked     = 0;
         triggers    = 0;
         power_downs = 0;
      endfunction

      function void reset_state();
         color_mode      = 1'b0;
         power_on        = 1'b1;
         sweep_reg       = '0;
         envelope_reg    = '0;
         duty_sel        = '0;
         length_left     = LEN_FULL;
         length_on       = 1'b0;
         freq_value      = '0;
         freq_countdown  = '0;
         duty_pos        = '0;
         chan_en         = 1'b0;
         dac_en          = 1'b0;
         vol             = '0;
         env_params      = '0;
         env_countdown   = '0;
         env_running     = 1'b0;
         sweep_params    = '0;
         sweep_countdown = '0;
         sweep_active    = 1'b0;
         negate_used     = 1'b0;
         sweep_shadow    = '0;
         seq_step        = '0;
         first_half      = 1'b0;
      endfunction

      function void set_color_mode(bit mode);
         color_mode = mode;
      endfunction

      function int pending();
         return status_q.size();
      endfunction

      // Next sweep frequency from the shadow; cut the channel on overflow
      function bit [11:0] next_sweep_freq();
         bit [11:0] delta;
         bit [11:0] nf;
         delta = {1'b0, sweep_shadow} >> sweep_params[2:0];
         if (sweep_params[3])
            nf = {1'b0, sweep_shadow} - delta;
         else
            nf = {1'b0, sweep_shadow} + delta;
         if (nf >= FREQ_SPAN)
            chan_en = 1'b0;
         if (sweep_params[3])
            negate_used = 1'b1;
         return nf;
      endfunction

      function bit [13:0] timer_period();
         return {FREQ_SPAN - {1'b0, freq_value}, 2'b00};
      endfunction

      function void write_sweep(bit [7:0] data);
         sweep_reg    = data;
         sweep_params = data[6:0];
         // leaving negate mode after a negated calculation cuts the channel
         if (!sweep_params[3] && negate_used)
            chan_en = 1'b0;
      endfunction

      function void write_envelope(bit [7:0] data);
         bit [4:0] v;
         v = {1'b0, vol};
         envelope_reg = data;
         // write while running nudges the volume
         if (chan_en) begin
            if ((env_params[2:0] == 3'd0 && env_running) || !env_params[3])
               v = v + 5'd1;
            if (data[3] != env_params[3])
               v = VOL_WRAP - v;
            vol = v[3:0];
         end
         env_params = data;
         dac_en     = (data[7:3] != 5'd0);
         if (!dac_en)
            chan_en = 1'b0;
      endfunction

      function void restart_channel();
         bit [13:0] period;
         period          = timer_period();
         triggers++;
         chan_en         = dac_en;
         sweep_params    = sweep_reg[6:0];
         sweep_shadow    = freq_value;
         sweep_countdown = (sweep_params[6:4] != 3'd0) ? {1'b0, sweep_params[6:4]}
                                                       : SWEEP_DEF_CNT;
         sweep_active    = (sweep_params[6:4] != 3'd0) || (sweep_params[2:0] != 3'd0);
         negate_used     = 1'b0;
         if (sweep_params[2:0] != 3'd0)
            void'(next_sweep_freq());
         env_params    = envelope_reg;
         env_countdown = env_params[2:0];
         vol           = env_params[7:4];
         env_running   = 1'b1;
         if (length_left == 7'd0) begin
            length_left = LEN_FULL;
            if (length_on && first_half)
               length_left = LEN_FULL_LESS;
         end
         // keep the two low timer bits
         freq_countdown = {period[13:2], freq_countdown[1:0]};
         duty_pos       = '0;
      endfunction

      function void write_freq_high(bit [7:0] data);
         freq_value = {data[2:0], freq_value[7:0]};
         // enabling the length counter in the first half clocks it once more
         if (first_half && data[6] && !length_on && length_left != 7'd0) begin
            length_left--;
            if (length_left == 7'd0)
               chan_en = 1'b0;
         end
         length_on = data[6];
         if (data[7])
            restart_channel();
      endfunction

      function void power_down();
         power_downs++;
         write_sweep(8'h00);
         duty_sel = '0;
         if (color_mode)
            length_left = LEN_FULL;
         write_envelope(8'h00);
         freq_value     = '0;
         length_on      = 1'b0;
         chan_en        = 1'b0;
         dac_en         = 1'b0;
         vol            = '0;
         freq_countdown = '0;
         duty_pos       = '0;
         first_half     = 1'b0;
         power_on       = 1'b0;
      endfunction

      function void apply_write(bit [2:0] idx, bit [7:0] data);
         if (idx == REG_POWER) begin
            if (data[7]) begin
               // only an off-to-on write restarts the sequencer
               if (!power_on) begin
                  if (color_mode)
                     length_left = '0;
                  seq_step = '0;
                  power_on = 1'b1;
               end
            end else begin
               power_down();
            end
         end else if (power_on) begin
            case (idx)
               REG_SWEEP:    write_sweep(data);
               REG_DUTY_LEN: begin
                  duty_sel    = data[7:6];
                  length_left = LEN_FULL - {1'b0, data[5:0]};
               end
               REG_ENVELOPE: write_envelope(data);
               REG_FREQ_LO:  freq_value = {freq_value[10:8], data};
               REG_FREQ_HI:  write_freq_high(data);
               default: ;
            endcase
         end
      endfunction

      function void step_sequencer();
         bit [11:0] nf;
         // length on even steps
         if (!seq_step[0] && length_on && length_left != 7'd0) begin
            length_left--;
            if (length_left == 7'd0)
               chan_en = 1'b0;
         end
         // sweep on steps 2 and 6
         if (seq_step[1:0] == 2'd2) begin
            if (sweep_countdown != 4'd0)
               sweep_countdown--;
            if (sweep_countdown == 4'd0) begin
               sweep_countdown = (sweep_params[6:4] != 3'd0) ? {1'b0, sweep_params[6:4]}
                                                             : SWEEP_DEF_CNT;
               if (sweep_active && sweep_params[6:4] != 3'd0) begin
                  nf = next_sweep_freq();
                  if (nf < FREQ_SPAN && sweep_params[2:0] != 3'd0) begin
                     sweep_shadow = nf[10:0];
                     freq_value   = nf[10:0];
                     void'(next_sweep_freq());
                  end
               end
            end
         end
         // envelope on step 7, stop at the limit
         if (seq_step == 3'd7 && env_params[2:0] != 3'd0 && env_running) begin
            if (env_countdown != 3'd0)
               env_countdown--;
            if (env_countdown == 3'd0) begin
               env_countdown = env_params[2:0];
               if (vol < VOL_MAX && env_params[3])
                  vol++;
               else if (vol != 4'd0 && !env_params[3])
                  vol--;
               else
                  env_running = 1'b0;
            end
         end
         first_half = !seq_step[0];
         seq_step   = seq_step + 3'd1;
      endfunction

      function void tick_timer();
         if (freq_countdown != 14'd0)
            freq_countdown--;
         if (freq_countdown == 14'd0) begin
            freq_countdown = timer_period();
            duty_pos       = duty_pos + 3'd1;
         end
      endfunction

      // Note an accepted item and queue the status it should produce
      function void take_request(sqch_req_type item);
         sqch_rsp_type want;
         case (item.action)
            ACT_WRITE: apply_write(item.reg_index, item.write_data);
            ACT_STEP:  if (power_on) step_sequencer();
            ACT_TICK:  if (power_on) tick_timer();
            default: ;
         endcase
         want.apu_on        = power_on;
         want.channel_on    = chan_en;
         want.dac_on        = dac_en;
         want.volume_level  = vol;
         want.duty_select   = duty_sel;
         want.duty_position = duty_pos;
         want.frequency     = freq_value;
         status_q.push_back(want);
         items++;
      endfunction

      function void check_field(string name, logic [10:0] want, logic [10:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // Compare one accepted result with the oldest queued status
      function void compare_status(sqch_rsp_type got);
         sqch_rsp_type want;
         if (status_q.size() == 0) begin
            $display("%0t: result with no item waiting, expected none actual %h", $time, got);
            errors++;
            return;
         end
         want = status_q.pop_front();
         checked++;
         check_field("apu_on", 11'(want.apu_on), 11'(got.apu_on));
         check_field("channel_on", 11'(want.channel_on), 11'(got.channel_on));
         check_field("dac_on", 11'(want.dac_on), 11'(got.dac_on));
         check_field("volume_level", 11'(want.volume_level), 11'(got.volume_level));
         check_field("duty_select", 11'(want.duty_select), 11'(got.duty_select));
         check_field("duty_position", 11'(want.duty_position), 11'(got.duty_position));
         check_field("frequency", want.frequency, got.frequency);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sqch_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   sqch_rsp_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic         csr_data;

   logic         calm_stretch;
   logic         long_hold;
   int           cycle_count;

   square_tracker tracker = new();

   square_channel_with_sweep i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap();
      if (calm_stretch)
         return 0;
      return $urandom_range(0, 11);
   endfunction

   function automatic sqch_req_type make_item(logic [1:0] action, logic [2:0] idx,
                                              logic [7:0] data);
      sqch_req_type item;
      item.action     = action;
      item.reg_index  = idx;
      item.write_data = data;
      return item;
   endfunction

   // High frequencies keep the timer period short so the duty position moves
   function automatic logic [7:0] freq_lo_byte();
      logic [7:0] data;
      data = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 50)
         data[7:4] = 4'hF;
      return data;
   endfunction

   function automatic logic [7:0] freq_hi_byte();
      logic [7:0] data;
      data = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 60)
         data[2:0] = 3'd7;
      return data;
   endfunction

   // Any action, any register, any byte
   function automatic sqch_req_type noise_item();
      logic [1:0] action;
      logic [2:0] idx;
      logic [7:0] data;
      action = 2'($urandom_range(0, 3));
      idx    = 3'($urandom_range(0, 7));
      data   = 8'($urandom_range(0, 255));
      if (action == ACT_WRITE && idx == REG_POWER && $urandom_range(0, 99) < 60)
         data[7] = 1'b1;
      return make_item(action, idx, data);
   endfunction

   // Mostly ticks and steps, with the odd channel register write
   function automatic sqch_req_type playing_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return make_item(ACT_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      if (r < 85)
         return make_item(ACT_STEP, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      if (r < 92)
         return make_item(ACT_WRITE, REG_ENVELOPE, 8'($urandom_range(0, 255)));
      if (r < 96)
         return make_item(ACT_WRITE, REG_SWEEP, 8'($urandom_range(0, 255)));
      return make_item(ACT_WRITE, REG_FREQ_HI, freq_hi_byte());
   endfunction

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input sqch_req_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      tracker.take_request(item);
   endtask

   // Drain the block, then write the color-mode bit
   task automatic write_color_mode(input logic mode);
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      tracker.set_color_mode(mode);
   endtask

   task automatic run_directed();
      send_item(make_item(ACT_TICK, REG_SWEEP, 8'h00));
      send_item(make_item(ACT_STEP, REG_SWEEP, 8'h00));
      send_item(make_item(ACT_UNUSED, REG_UNUSED_7, 8'hFF));
      send_item(make_item(ACT_WRITE, REG_UNUSED_6, 8'hFF));
      send_item(make_item(ACT_WRITE, REG_UNUSED_7, 8'h00));
      // full volume, fading; longest duty, shortest length; negated sweep
      send_item(make_item(ACT_WRITE, REG_ENVELOPE, 8'hF0));
      send_item(make_item(ACT_WRITE, REG_DUTY_LEN, 8'hFF));
      send_item(make_item(ACT_WRITE, REG_SWEEP, 8'h7F));
      send_item(make_item(ACT_WRITE, REG_FREQ_LO, 8'hFF));
      send_item(make_item(ACT_WRITE, REG_FREQ_HI, 8'hC7));
      // envelope write while running, then leave negate mode
      send_item(make_item(ACT_WRITE, REG_ENVELOPE, 8'h18));
      send_item(make_item(ACT_WRITE, REG_SWEEP, 8'h11));
      send_item(make_item(ACT_WRITE, REG_FREQ_HI, 8'h87));
      repeat (4) send_item(make_item(ACT_STEP, REG_SWEEP, 8'h00));
      repeat (2) send_item(make_item(ACT_TICK, REG_SWEEP, 8'h00));
      // power off, poke while off, power back on, then a second power-on write
      send_item(make_item(ACT_WRITE, REG_POWER, 8'h00));
      send_item(make_item(ACT_WRITE, REG_ENVELOPE, 8'hFF));
      send_item(make_item(ACT_TICK, REG_SWEEP, 8'h00));
      send_item(make_item(ACT_STEP, REG_SWEEP, 8'h00));
      send_item(make_item(ACT_WRITE, REG_POWER, 8'h80));
      send_item(make_item(ACT_WRITE, REG_POWER, 8'hFF));
   endtask

   // Mostly whole notes (set up, trigger, play), the rest noise
   task automatic run_random(input int count);
      int sent;
      int run;
      sent = 0;
      while (sent < count) begin
         calm_stretch <= ($urandom_range(0, 99) < 15);
         if ($urandom_range(0, 99) < 70) begin
            if (!tracker.power_on) begin
               send_item(make_item(ACT_WRITE, REG_POWER, 8'h80 | 8'($urandom_range(0, 127))));
               sent++;
            end
            send_item(make_item(ACT_WRITE, REG_ENVELOPE, 8'($urandom_range(0, 255))));
            send_item(make_item(ACT_WRITE, REG_DUTY_LEN, 8'($urandom_range(0, 255))));
            send_item(make_item(ACT_WRITE, REG_SWEEP, 8'($urandom_range(0, 255))));
            send_item(make_item(ACT_WRITE, REG_FREQ_LO, freq_lo_byte()));
            send_item(make_item(ACT_WRITE, REG_FREQ_HI, freq_hi_byte() | 8'h80));
            sent += 5;
            run = $urandom_range(10, 60);
            repeat (run) send_item(playing_item());
            sent += run;
         end else begin
            run = $urandom_range(1, 8);
            repeat (run) send_item(noise_item());
            sent += run;
         end
      end
   endtask

   // Result side: take results, hold off a random count after each
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            tracker.compare_status(rsp_data);
            hold_left = draw_gap();
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || long_hold;
      end
   end

   // Hold off the result side for a long stretch so the input backs up
   initial begin
      long_hold <= 1'b0;
      while (tracker.checked < LONG_HOLD_AFTER)
         @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Main sequence
   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_valid    <= 1'b0;
      csr_data     <= 1'b0;
      calm_stretch <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_color_mode(1'b0);
      run_directed();
      write_color_mode(1'b1);
      run_random(PHASE_ITEMS);
      write_color_mode(1'b0);
      run_random(PHASE_ITEMS);
      write_color_mode(1'b1);
      run_random(PHASE_ITEMS);

      // drain
      req_valid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items with %0d triggers and %0d power-downs in both color modes,",
               tracker.items, tracker.triggers, tracker.power_downs);
      $display("including a long result hold-off; %0d results compared, %0d mismatches.",
               tracker.checked, tracker.errors);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
